// ===== src/phps_pkg.sv =====
// Package for the path heading PID steering unit.
// Constants, operation and status codes, command and status structs.
// No dependencies.
`default_nettype none
package phps_pkg;
   // path storage
   localparam int PATH_DEPTH = 256;
   localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
   localparam int CW = $clog2(PATH_DEPTH + 1);
   localparam int WP_W = 80; // x, y, heading

   // steering clamp in Q8.8 degrees
   localparam int STEER_LIMIT_DEG = 70;
   localparam logic signed [15:0] STEER_LIM = 16'(STEER_LIMIT_DEG * 256);

   // operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_STEP   = 2'd2;
   localparam logic [1:0] OP_STOP   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_STEER   = 2'd0;
   localparam logic [1:0] ST_BRAKE   = 2'd1;
   localparam logic [1:0] ST_NO_PATH = 2'd2;
   localparam logic [1:0] ST_END     = 2'd3;

   // register indexes
   localparam logic [1:0] REG_KP = 2'd0;
   localparam logic [1:0] REG_KI = 2'd1;
   localparam logic [1:0] REG_KD = 2'd2;

   // multiplier operand select
   localparam logic [1:0] MUL_P = 2'd0;
   localparam logic [1:0] MUL_I = 2'd1;
   localparam logic [1:0] MUL_D = 2'd2;

   typedef struct packed {
      logic          clear_path;
      logic          append;
      logic          set_stop;
      logic          load_odo;
      logic          rd_en;
      logic [AW-1:0] rd_addr;
      logic          scan_issue;
      logic          scan_init;
      logic          pid_load;
      logic [1:0]    mul_sel;
      logic          acc_load;
      logic          acc_add;
      logic          round_en;
      logic          rsp_load;
      logic [1:0]    rsp_status;
   } phps_cmd_type;

   typedef struct packed {
      logic [CW-1:0] count;
      logic          estop;
      logic [AW-1:0] best;
      logic          scan_busy;
      logic          rsp_free;
   } phps_stat_type;
endpackage
`default_nettype wire

// ===== src/phps_chan_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing.
`default_nettype none
interface phps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [15:0] heading;
   logic        stop_request;
   modport source (output valid, operation, pos_x, pos_y, heading, stop_request,
                   input ready);
   modport sink (input valid, operation, pos_x, pos_y, heading, stop_request,
                 output ready);
endinterface

interface phps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] steering_deg;
   logic        brake_full;
   logic [7:0]  waypoint_index;
   modport source (output valid, status, steering_deg, brake_full, waypoint_index,
                   input ready);
   modport sink (input valid, status, steering_deg, brake_full, waypoint_index,
                 output ready);
endinterface
`default_nettype wire

// ===== src/phps_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module phps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== src/phps_ctrl.sv =====
// Controller: sequences path writes, the nearest waypoint scan and the PID steps.
// Depends on phps_pkg.
`default_nettype none
module phps_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_operation,
   output logic                       req_ready,
   input  wire phps_pkg::phps_stat_type stat,
   output phps_pkg::phps_cmd_type     cmd
);
   import phps_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_DRAIN = 4'd2;
   localparam logic [3:0] S_NEXT  = 4'd3;
   localparam logic [3:0] S_HEAD  = 4'd4;
   localparam logic [3:0] S_MUL0  = 4'd5;
   localparam logic [3:0] S_MUL1  = 4'd6;
   localparam logic [3:0] S_MUL2  = 4'd7;
   localparam logic [3:0] S_MUL3  = 4'd8;
   localparam logic [3:0] S_ROUND = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [1:0]    status_ff, status_in;
   logic [CW-1:0] next_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign next_idx  = CW'(stat.best) + CW'(1);

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      status_in   = status_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_CLEAR:  cmd.clear_path = 1'b1;
                  OP_APPEND: cmd.append = 1'b1;
                  OP_STOP:   cmd.set_stop = 1'b1;
                  default: begin
                     cmd.load_odo = 1'b1;
                     if (stat.count == '0) begin
                        status_in = ST_NO_PATH;
                        state_in  = S_DONE;
                     end else if (stat.estop) begin
                        status_in = ST_BRAKE;
                        state_in  = S_DONE;
                     end else begin
                        cmd.scan_init = 1'b1;
                        scan_idx_in   = '0;
                        state_in      = S_SCAN;
                     end
                  end
               endcase
            end
         end
         // one waypoint read per cycle
         S_SCAN: begin
            cmd.rd_en      = 1'b1;
            cmd.rd_addr    = scan_idx_ff[AW-1:0];
            cmd.scan_issue = 1'b1;
            scan_idx_in    = scan_idx_ff + CW'(1);
            if (scan_idx_ff == stat.count - CW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.scan_busy) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (next_idx >= stat.count) begin
               status_in = ST_END;
               state_in  = S_DONE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = next_idx[AW-1:0];
               state_in    = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.pid_load = 1'b1;
            state_in     = S_MUL0;
         end
         S_MUL0: begin
            cmd.mul_sel = MUL_P;
            state_in    = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_sel  = MUL_I;
            cmd.acc_load = 1'b1;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_sel = MUL_D;
            cmd.acc_add = 1'b1;
            state_in    = S_MUL3;
         end
         S_MUL3: begin
            cmd.acc_add = 1'b1;
            state_in    = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            status_in    = ST_STEER;
            state_in     = S_DONE;
         end
         S_DONE: begin
            cmd.rsp_status = status_ff;
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      scan_idx_ff <= scan_idx_in;
      status_ff   <= status_in;
   end
endmodule
`default_nettype wire

// ===== src/phps_dp.sv =====
// Datapath: path RAM, distance pipeline, PID arithmetic and the response register.
// Depends on phps_pkg and phps_ram.
`default_nettype none
module phps_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire phps_pkg::phps_cmd_type cmd,
   output phps_pkg::phps_stat_type     stat,
   input  wire logic [31:0]            req_pos_x,
   input  wire logic [31:0]            req_pos_y,
   input  wire logic [15:0]            req_heading,
   input  wire logic                   req_stop_request,
   input  wire logic                   csr_write_en,
   input  wire logic [1:0]             csr_index,
   input  wire logic [15:0]            csr_write_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [15:0]                 rsp_steering_deg,
   output logic                        rsp_brake_full,
   output logic [7:0]                  rsp_waypoint_index
);
   import phps_pkg::*;

   // gains
   logic signed [15:0] kp_ff, ki_ff, kd_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= 16'sd256;
         ki_ff <= 16'sd0;
         kd_ff <= 16'sd26;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_KP:  kp_ff <= csr_write_data;
            REG_KI:  ki_ff <= csr_write_data;
            REG_KD:  kd_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // path count and emergency stop
   logic [CW-1:0] count_ff;
   logic          estop_ff;
   logic          wr_en;
   assign wr_en = cmd.append && (count_ff < CW'(PATH_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         estop_ff <= 1'b0;
      end else begin
         if (cmd.clear_path) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.set_stop) begin
            estop_ff <= req_stop_request;
         end
      end
   end

   logic [WP_W-1:0] rd_data;
   phps_ram #(.WIDTH(WP_W), .DEPTH(PATH_DEPTH)) u_path_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_pos_x, req_pos_y, req_heading}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   logic signed [31:0] wp_x, wp_y;
   logic [15:0]        wp_hd;
   assign wp_x  = rd_data[79:48];
   assign wp_y  = rd_data[47:16];
   assign wp_hd = rd_data[15:0];

   // vehicle pose of the current step
   logic signed [31:0] px_ff, py_ff;
   logic [15:0]        hd_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_odo) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         hd_ff <= req_heading;
      end
   end

   // distance pipeline: read, abs diff, square, compare
   logic          p0_ff, p1_ff, p2_ff;
   logic [AW-1:0] i0_ff, i1_ff, i2_ff;
   logic [31:0]   dx_ff, dy_ff;
   logic [63:0]   sx_ff, sy_ff;
   logic signed [32:0] dxs, dys;
   logic [64:0]   sq_sum;
   logic [64:0]   best_d_ff;
   logic [AW-1:0] best_ff;

   assign dxs    = 33'(wp_x) - 33'(px_ff);
   assign dys    = 33'(wp_y) - 33'(py_ff);
   assign sq_sum = 65'(sx_ff) + 65'(sy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff <= 1'b0;
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
      end else begin
         p0_ff <= cmd.scan_issue;
         p1_ff <= p0_ff;
         p2_ff <= p1_ff;
      end
      i0_ff <= cmd.rd_addr;
      i1_ff <= i0_ff;
      i2_ff <= i1_ff;
      dx_ff <= dxs[32] ? 32'(-dxs) : dxs[31:0];
      dy_ff <= dys[32] ? 32'(-dys) : dys[31:0];
      sx_ff <= 64'(dx_ff) * 64'(dx_ff);
      sy_ff <= 64'(dy_ff) * 64'(dy_ff);
      // strict less keeps the first minimum
      if (cmd.scan_init) begin
         best_d_ff <= '1;
         best_ff   <= '0;
      end else if (p2_ff && (sq_sum < best_d_ff || i2_ff == '0)) begin
         best_d_ff <= sq_sum;
         best_ff   <= i2_ff;
      end
   end

   // heading error and integral
   logic [15:0]        err;
   logic signed [22:0] e_scaled, l_scaled;
   logic signed [16:0] e_deg, l_deg;
   logic signed [32:0] sum_raw;
   logic signed [31:0] sum_sat;
   logic signed [15:0] last_err_ff;
   logic signed [31:0] esum_ff;
   logic signed [16:0] e_ff;
   logic signed [17:0] d_ff;

   assign err      = wp_hd - hd_ff;
   assign e_scaled = 23'($signed(err)) * 23'sd45 + 23'sd16;
   assign l_scaled = 23'(last_err_ff) * 23'sd45 + 23'sd16;
   assign e_deg    = e_scaled[21:5];
   assign l_deg    = l_scaled[21:5];
   assign sum_raw  = 33'(esum_ff) + 33'(e_deg);

   always_comb begin
      if (sum_raw[32] != sum_raw[31]) begin
         sum_sat = sum_raw[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sum_sat = sum_raw[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         esum_ff     <= '0;
      end else if (cmd.pid_load) begin
         last_err_ff <= $signed(err);
         esum_ff     <= sum_sat;
      end
      if (cmd.pid_load) begin
         e_ff <= e_deg;
         d_ff <= 18'(e_deg) - 18'(l_deg);
      end
   end

   // shared 16x32 multiplier and accumulator
   logic signed [15:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [47:0] prod_ff;
   logic signed [49:0] acc_ff;
   always_comb begin
      case (cmd.mul_sel)
         MUL_P: begin
            mul_a = kp_ff;
            mul_b = 32'(e_ff);
         end
         MUL_I: begin
            mul_a = ki_ff;
            mul_b = esum_ff;
         end
         default: begin
            mul_a = kd_ff;
            mul_b = 32'(d_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 48'(mul_a) * 48'(mul_b);
      if (cmd.acc_load) begin
         acc_ff <= 50'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + 50'(prod_ff);
      end
   end

   // round to Q8.8 and clamp
   logic signed [49:0] acc_rnd;
   logic signed [41:0] st_full;
   logic signed [15:0] steer_ff;
   assign acc_rnd = acc_ff + 50'sd128;
   assign st_full = acc_rnd[49:8];
   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         if (st_full > 42'(STEER_LIM)) begin
            steer_ff <= STEER_LIM;
         end else if (st_full < -42'(STEER_LIM)) begin
            steer_ff <= -STEER_LIM;
         end else begin
            steer_ff <= st_full[15:0];
         end
      end
   end

   // response register
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [15:0] rsp_steer_ff;
   logic       rsp_brake_ff;
   logic [7:0] rsp_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_steer_ff  <= (cmd.rsp_status == ST_STEER) ? steer_ff : '0;
         rsp_brake_ff  <= (cmd.rsp_status == ST_BRAKE);
         rsp_idx_ff    <= (cmd.rsp_status == ST_STEER || cmd.rsp_status == ST_END)
                          ? 8'(best_ff) : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_steering_deg   = rsp_steer_ff;
   assign rsp_brake_full     = rsp_brake_ff;
   assign rsp_waypoint_index = rsp_idx_ff;

   assign stat.count     = count_ff;
   assign stat.estop     = estop_ff;
   assign stat.best      = best_ff;
   assign stat.scan_busy = p0_ff | p1_ff | p2_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;
endmodule
`default_nettype wire

// ===== src/path_heading_pid_steer_unit.sv =====
// Heading PID steering over a stored waypoint path.
// Channel req_chan carries path edits, stop control and odometry beats; a
// odometry step returns one beat on rsp_chan, the other operations none.
// csr_* writes the P, I and D gains (signed Q8.8); index 3 is ignored.
// Path clear, append and stop leave the block idle, so the next beat is taken
// on the following cycle.
// An odometry step with a path of N waypoints scans every waypoint through a
// single read port of the path RAM, one per cycle, then reads the next
// waypoint heading and runs the three PID products through one shared
// multiplier before the response is loaded.
// No path and emergency stop answer without a scan; end of path answers after
// the scan, without the PID products.
// One item is in work at a time; req_chan.ready is high only while idle.
// A finished beat waits in the response register while the next request is
// taken; if the receiver stalls, the following step waits before loading it.
// Synchronous reset empties the path, clears the integral, last error and
// stop flag, and loads the default gains. Stored waypoints are not cleared.
// Depends on phps_pkg, phps_chan_if, phps_ctrl, phps_dp, phps_ram.
`default_nettype none
module path_heading_pid_steer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   phps_req_if.sink         req_chan,
   phps_rsp_if.source       rsp_chan,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import phps_pkg::*;

   phps_cmd_type  cmd;
   phps_stat_type stat;

   phps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   phps_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_pos_x          (req_chan.pos_x),
      .req_pos_y          (req_chan.pos_y),
      .req_heading        (req_chan.heading),
      .req_stop_request   (req_chan.stop_request),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_status         (rsp_chan.status),
      .rsp_steering_deg   (rsp_chan.steering_deg),
      .rsp_brake_full     (rsp_chan.brake_full),
      .rsp_waypoint_index (rsp_chan.waypoint_index)
   );

   // a step keeps the block busy past its accept cycle
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.operation == OP_STEP)
      |=> !req_chan.ready)
      else $error("request taken right after an odometry step");

   // steering stays inside the clamp
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ($signed(rsp_chan.steering_deg) <= STEER_LIM &&
                          $signed(rsp_chan.steering_deg) >= -STEER_LIM))
      else $error("steering outside limit");

   // brake flag matches the status code
   a_brake_status: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.brake_full == (rsp_chan.status == ST_BRAKE)))
      else $error("brake flag disagrees with status");

   // no-path and brake beats carry zero index and steering
   a_no_path_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_NO_PATH ||
                          rsp_chan.status == ST_BRAKE))
      |-> (rsp_chan.waypoint_index == 8'd0 && rsp_chan.steering_deg == 16'd0))
      else $error("nonzero fields on a no-path or brake beat");
endmodule
`default_nettype wire

// ===== tb/phps_checker.sv =====
// Checker for the path heading PID steering unit: watches both channels,
// models the path store and PID state, and compares every response beat.
// Depends on phps_pkg and phps_chan_if.
`timescale 1ns / 100ps
module phps_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   phps_req_if              req_chan,
   phps_rsp_if              rsp_chan,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   output int               fail_count,
   output int               pending_count
);
   import phps_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] steering_deg;
      logic        brake_full;
      logic [7:0]  waypoint_index;
   } steer_rsp_type;

   logic signed [15:0] kp, ki, kd;
   logic signed [31:0] path_x [PATH_DEPTH];
   logic signed [31:0] path_y [PATH_DEPTH];
   logic [15:0]        path_hd [PATH_DEPTH];
   int                 path_len;
   logic signed [31:0] integ;
   logic signed [15:0] prev_err;
   logic               estop;
   steer_rsp_type      steer_queue [$];

   // binary angle to Q8.8 degrees, halves rounded up
   function automatic longint angle_to_deg(longint e);
      longint v;
      v = e * 45 + 16;
      return (v >= 0) ? v / 32 : -((-v + 31) / 32);
   endfunction

   // apply one accepted request beat; returns 1 with a response when one is due
   function automatic bit steer_step(logic [1:0] op, logic signed [31:0] px,
                                     logic signed [31:0] py, logic [15:0] hd,
                                     logic stop, output steer_rsp_type r);
      int         best;
      logic [64:0] sq_sum, best_sq;
      logic [63:0] ux, uy;
      longint     dx, dy, ed, dd, sum, ctl, st, v;
      logic [15:0] diff;
      r = '0;
      case (op)
         OP_CLEAR: begin path_len = 0; return 0; end
         OP_APPEND: begin
            if (path_len < PATH_DEPTH) begin
               path_x[path_len] = px; path_y[path_len] = py;
               path_hd[path_len] = hd; path_len++;
            end
            return 0;
         end
         OP_STOP: begin estop = stop; return 0; end
         default: ;
      endcase
      if (path_len == 0) begin r.status = ST_NO_PATH; return 1; end
      if (estop) begin r.status = ST_BRAKE; r.brake_full = 1; return 1; end
      best = 0;
      best_sq = '1;
      for (int i = 0; i < path_len; i++) begin
         dx = longint'(path_x[i]) - longint'(px);
         dy = longint'(path_y[i]) - longint'(py);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         ux = 64'(dx);
         uy = 64'(dy);
         // squares below 2**64, summed in 65 bits
         sq_sum = {1'b0, ux * ux} + {1'b0, uy * uy};
         if (i == 0 || sq_sum < best_sq) begin best = i; best_sq = sq_sum; end
      end
      r.waypoint_index = best[7:0];
      if (best + 1 >= path_len) begin r.status = ST_END; return 1; end
      diff = path_hd[best + 1] - hd;
      ed = angle_to_deg(longint'($signed(diff)));
      dd = ed - angle_to_deg(longint'(prev_err));
      sum = longint'(integ) + ed;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      integ = 32'(sum);
      prev_err = $signed(diff);
      ctl = longint'(kp) * ed + longint'(ki) * sum + longint'(kd) * dd;
      v = ctl + 128;
      st = (v >= 0) ? v / 256 : -((-v + 255) / 256);
      if (st > STEER_LIMIT_DEG * 256) st = STEER_LIMIT_DEG * 256;
      if (st < -STEER_LIMIT_DEG * 256) st = -STEER_LIMIT_DEG * 256;
      r.status = ST_STEER;
      r.steering_deg = 16'(st);
      return 1;
   endfunction

   assign pending_count = steer_queue.size();

   always @(posedge clock) begin
      steer_rsp_type exp_rsp, got;
      if (reset) begin
         kp <= 16'sd256; ki <= 16'sd0; kd <= 16'sd26;
         path_len = 0; integ = 0; prev_err = 0; estop = 0;
         steer_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_KP: kp <= csr_write_data;
               REG_KI: ki <= csr_write_data;
               REG_KD: kd <= csr_write_data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            if (steer_step(req_chan.operation, req_chan.pos_x, req_chan.pos_y,
                           req_chan.heading, req_chan.stop_request, exp_rsp))
               steer_queue.push_back(exp_rsp);
         end
         // response beat against oldest expectation
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.status, rsp_chan.steering_deg, rsp_chan.brake_full,
                   rsp_chan.waypoint_index};
            if (steer_queue.size() == 0) begin
               $error("unexpected response beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = steer_queue.pop_front();
               if (got.status !== exp_rsp.status)
                  $error("status exp %0d got %0d", exp_rsp.status, got.status);
               if (got.steering_deg !== exp_rsp.steering_deg)
                  $error("steering_deg exp %0d got %0d", $signed(exp_rsp.steering_deg),
                         $signed(got.steering_deg));
               if (got.brake_full !== exp_rsp.brake_full)
                  $error("brake_full exp %0d got %0d", exp_rsp.brake_full, got.brake_full);
               if (got.waypoint_index !== exp_rsp.waypoint_index)
                  $error("waypoint_index exp %0d got %0d", exp_rsp.waypoint_index,
                         got.waypoint_index);
               if (got !== exp_rsp) fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

// ===== tb/tb.sv =====
// Top of the steering unit testbench: clock, reset, gain writes and request
// stimulus with bursty sender and stalling receiver; checker gives verdict.
// Depends on phps_pkg, phps_chan_if, phps_checker and the unit itself.
`timescale 1ns / 100ps
module tb;
   import phps_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   // index past the last gain register
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_en = 0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   bit          stall_mode = 0;

   phps_req_if req_chan ();
   phps_rsp_if rsp_chan ();

   path_heading_pid_steer_unit i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   phps_checker i_checker (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always #4 clock = ~clock;

   initial begin
      req_chan.valid = 0; req_chan.operation = '0; req_chan.pos_x = '0;
      req_chan.pos_y = '0; req_chan.heading = '0; req_chan.stop_request = 0;
      rsp_chan.ready = 0;
   end

   // receiver stall pattern: phases of always ready and of random stalls
   always @(posedge clock) begin
      if ((cycle_count % 2000) == 0) stall_mode <= 1'($urandom_range(0, 1));
      rsp_chan.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   int burst_left = 0;

   // one request beat, with bursts and gaps before it; valid stays high
   // across back-to-back beats and drops only for a gap
   task automatic send_beat(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                            logic [15:0] hd, logic stop);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_chan.valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1; req_chan.operation <= op; req_chan.pos_x <= px;
      req_chan.pos_y <= py; req_chan.heading <= hd; req_chan.stop_request <= stop;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_gain(logic [1:0] idx, logic [15:0] val);
      csr_write_en <= 1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   task automatic drain_wait();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
         default: return 32'($signed($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   initial begin
      int mode, len;
      logic [15:0] gains [3];
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty path, stop, end of path, extremes
      send_beat(OP_STEP, '0, '0, '0, 1'b0);
      send_beat(OP_STOP, '0, '0, '0, 1'b1);
      send_beat(OP_STEP, '0, '0, '0, 1'b0);
      send_beat(OP_APPEND, 32'h7fffffff, 32'h80000000, 16'hffff, 1'b0);
      send_beat(OP_STEP, '0, '0, '0, 1'b0);
      send_beat(OP_STOP, '0, '0, '0, 1'b0);
      send_beat(OP_STEP, 32'h7fffffff, 32'h80000000, 16'h0000, 1'b0);
      send_beat(OP_APPEND, 32'h80000000, 32'h7fffffff, 16'h8000, 1'b0);
      send_beat(OP_APPEND, '0, '0, 16'h0000, 1'b0);
      send_beat(OP_STEP, 32'h80000000, 32'h80000000, 16'h0000, 1'b1);
      send_beat(OP_STEP, 32'h80000000, 32'h7fffffff, 16'h7fff, 1'b0);
      send_beat(OP_STEP, 32'h7fffffff, 32'h80000000, 16'h8000, 1'b0);
      send_beat(OP_STEP, 32'h7fffffff, 32'h80000000, 16'hffff, 1'b0);
      send_beat(OP_CLEAR, 32'hffffffff, 32'hffffffff, 16'hffff, 1'b1);
      send_beat(OP_STEP, '0, '0, '0, 1'b0);
      drain_wait();
      write_gain(REG_KP, 16'h7fff);
      write_gain(REG_KI, 16'h7fff);
      write_gain(REG_KD, 16'h8000);
      write_gain(REG_UNUSED, 16'h1234);
      // full path plus overflow appends; large index
      for (int i = 0; i < PATH_DEPTH + 2; i++)
         send_beat(OP_APPEND, 32'(i) <<< 16, '0, 16'(i * 300), 1'b0);
      send_beat(OP_STEP, 32'd200 <<< 16, '0, '0, 1'b0);
      send_beat(OP_STEP, 32'd255 <<< 16, '0, '0, 1'b0);
      send_beat(OP_STEP, 32'd20 <<< 16, '0, 16'h8000, 1'b0);

      // random phases with different gains and small paths
      for (int ph = 0; ph < 12; ph++) begin
         drain_wait();
         for (int g = 0; g < 3; g++)
            case ($urandom_range(0, 3))
               0: gains[g] = 16'h8000;
               1: gains[g] = 16'h7fff;
               2: gains[g] = 16'($signed($urandom_range(0, 1024)) - 512);
               default: gains[g] = 16'($urandom());
            endcase
         write_gain(REG_KP, gains[0]);
         write_gain(REG_KI, gains[1]);
         write_gain(REG_KD, gains[2]);
         mode = $urandom_range(0, 2);
         send_beat(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()), 1'($urandom()));
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++)
            send_beat(OP_APPEND, rand_coord(mode), rand_coord(mode), 16'($urandom()),
                      1'b0);
         for (int n = 0; n < 50; n++) begin
            case ($urandom_range(0, 19))
               0: send_beat(OP_STOP, $urandom(), $urandom(), 16'($urandom()),
                            1'($urandom_range(0, 1)));
               1: send_beat(OP_STOP, '0, '0, '0, 1'b0);
               2: send_beat(OP_APPEND, rand_coord(mode), rand_coord(mode),
                            16'($urandom()), 1'($urandom_range(0, 1)));
               3: if ($urandom_range(0, 3) == 0)
                     send_beat(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()), 1'b0);
               default: send_beat(OP_STEP, rand_coord(mode), rand_coord(mode),
                                  16'($urandom()), 1'($urandom_range(0, 1)));
            endcase
         end
      end

      drain_wait();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ===== path_heading_pid_steer_unit.f =====
src/phps_pkg.sv
src/phps_chan_if.sv
src/phps_ram.sv
src/phps_ctrl.sv
src/phps_dp.sv
src/path_heading_pid_steer_unit.sv
tb/phps_checker.sv
tb/tb.sv
